@@ rtl/core/biphase_mark_frame_transmitter_assert.svh @@
// Assertion macros shared by the transmitter RTL.
// Both sample on the rising edge of clk and are off while rst is high.
`ifndef BIPHASE_MARK_FRAME_TRANSMITTER_ASSERT_SVH
`define BIPHASE_MARK_FRAME_TRANSMITTER_ASSERT_SVH

// Same-cycle implication.
`define BMFT_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bmft assertion failed");

// Next-cycle implication.
`define BMFT_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bmft assertion failed");

`endif

@@ rtl/core/bmft_pkg.sv @@
package bmft_pkg;

  localparam int unsigned PRE_W     = 6;
  localparam int unsigned CNT_W     = 6;
  localparam int unsigned DATA_BITS = 8;
  localparam int unsigned STOP_SLOTS = 5;

  localparam logic [PRE_W-1:0] PREAMBLE_MIN   = 6'd1;
  localparam logic [PRE_W-1:0] PREAMBLE_MAX   = 6'd40;
  localparam logic [PRE_W-1:0] PREAMBLE_RESET = 6'd16;

  typedef enum logic [1:0] {
    KIND_PREAMBLE = 2'd0,
    KIND_START    = 2'd1,
    KIND_DATA     = 2'd2,
    KIND_STOP     = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    TOG_NEVER  = 2'd0,
    TOG_ALWAYS = 2'd1,
    TOG_BIT    = 2'd2
  } tog_t;

  typedef struct packed {
    logic  load;     // capture a new item
    logic  emit;     // produce one slot into the output register
    kind_t kind;
    tog_t  tog;
    logic  shift;    // advance to the next data bit
    logic  cnt_clr;  // restart the slot counter for the next phase
    logic  fin;      // final slot of the item
    logic  open;     // frame is open once start bits go out
  } cmd_t;

  typedef struct packed {
    logic             out_free;
    logic             frame_open;
    logic             pre_last;
    logic [CNT_W-1:0] cnt;
  } status_t;

endpackage

@@ rtl/core/bmft_dp.sv @@
module bmft_dp import bmft_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_wr_en,
  input  logic [PRE_W-1:0] cfg_wr_data,
  input  logic [7:0]       data_byte,
  input  logic             last_byte,
  input  logic             out_ready,
  input  cmd_t             cmd,
  output status_t          status,
  output logic             out_valid,
  output logic             line_level,
  output logic [1:0]       slot_kind,
  output logic             last,
  output logic             frame_end
);

  logic [PRE_W-1:0] preamble_ticks;
  logic [PRE_W-1:0] pre_eff;
  logic [7:0]       byte_reg;
  logic             last_reg;
  logic             carrier;
  logic             frame_open;
  logic [CNT_W-1:0] cnt;
  logic             toggle;
  logic             carrier_next;

  // clamp the register into its legal range
  always_comb begin
    if (preamble_ticks < PREAMBLE_MIN) begin
      pre_eff = PREAMBLE_MIN;
    end else if (preamble_ticks > PREAMBLE_MAX) begin
      pre_eff = PREAMBLE_MAX;
    end else begin
      pre_eff = preamble_ticks;
    end
  end

  always_comb begin
    case (cmd.tog)
      TOG_NEVER:  toggle = 1'b0;
      TOG_ALWAYS: toggle = 1'b1;
      TOG_BIT:    toggle = byte_reg[0];
      default:    toggle = 1'b0;
    endcase
  end

  assign carrier_next = carrier ^ toggle;

  assign status.out_free   = !out_valid || out_ready;
  assign status.frame_open = frame_open;
  assign status.pre_last   = (cnt == (pre_eff - 6'd1));
  assign status.cnt        = cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      preamble_ticks <= PREAMBLE_RESET;
      carrier        <= 1'b0;
      frame_open     <= 1'b0;
      out_valid      <= 1'b0;
      cnt            <= '0;
    end else begin
      if (cfg_wr_en) begin
        preamble_ticks <= cfg_wr_data;
      end
      if (cmd.load || cmd.cnt_clr) begin
        cnt <= '0;
      end else if (cmd.emit) begin
        cnt <= cnt + 6'd1;
      end
      if (cmd.emit) begin
        carrier   <= carrier_next;
        out_valid <= 1'b1;
        if (cmd.open) begin
          frame_open <= 1'b1;
        end
        if (cmd.fin && last_reg) begin
          frame_open <= 1'b0;
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      byte_reg <= data_byte;
      last_reg <= last_byte;
    end else if (cmd.emit && cmd.shift) begin
      byte_reg <= {1'b0, byte_reg[7:1]};
    end
    if (cmd.emit) begin
      line_level <= carrier_next;
      slot_kind  <= cmd.kind;
      last       <= cmd.fin;
      frame_end  <= cmd.fin && last_reg;
    end
  end

endmodule

@@ rtl/core/bmft_ctrl.sv @@
module bmft_ctrl import bmft_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  status_t status,
  output cmd_t    cmd
);

  localparam logic [CNT_W-1:0] START_LAST = 6'd1;
  localparam logic [CNT_W-1:0] DATA_LAST  = CNT_W'(2 * DATA_BITS - 1);
  localparam logic [CNT_W-1:0] STOP_LAST  = CNT_W'(STOP_SLOTS - 1);

  typedef enum logic [4:0] {
    ST_IDLE     = 5'b00001,
    ST_PREAMBLE = 5'b00010,
    ST_START    = 5'b00100,
    ST_DATA     = 5'b01000,
    ST_STOP     = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready = (state == ST_IDLE);

  always_comb begin
    state_next  = state;
    cmd         = '0;
    cmd.kind    = KIND_PREAMBLE;
    cmd.tog     = TOG_NEVER;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = status.frame_open ? ST_START : ST_PREAMBLE;
        end
      end
      ST_PREAMBLE: begin
        cmd.kind = KIND_PREAMBLE;
        cmd.tog  = TOG_ALWAYS;
        if (status.out_free) begin
          cmd.emit = 1'b1;
          if (status.pre_last) begin
            cmd.cnt_clr = 1'b1;
            state_next  = ST_START;
          end
        end
      end
      ST_START: begin
        cmd.kind = KIND_START;
        cmd.open = 1'b1;
        if (status.out_free) begin
          cmd.emit = 1'b1;
          if (status.cnt == START_LAST) begin
            cmd.cnt_clr = 1'b1;
            state_next  = ST_DATA;
          end
        end
      end
      ST_DATA: begin
        // first half always toggles, second half toggles on a one
        cmd.kind  = KIND_DATA;
        cmd.tog   = status.cnt[0] ? TOG_BIT : TOG_ALWAYS;
        cmd.shift = status.cnt[0];
        if (status.out_free) begin
          cmd.emit = 1'b1;
          if (status.cnt == DATA_LAST) begin
            cmd.cnt_clr = 1'b1;
            state_next  = ST_STOP;
          end
        end
      end
      ST_STOP: begin
        cmd.kind = KIND_STOP;
        cmd.tog  = TOG_ALWAYS;
        if (status.out_free) begin
          cmd.emit = 1'b1;
          if (status.cnt == STOP_LAST) begin
            cmd.fin     = 1'b1;
            cmd.cnt_clr = 1'b1;
            state_next  = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

@@ rtl/core/biphase_mark_frame_transmitter.sv @@
// Channel  | Handshake            | Payload
// ---------+----------------------+-------------------------------------------
// input    | in_valid / in_ready  | data_byte[7:0], last_byte
// output   | out_valid / out_ready| line_level, slot_kind[1:0], last, frame_end
// config   | cfg_wr_en            | cfg_wr_data[5:0] (preamble_ticks)
//
// Each item is one accept followed by 23 slots (start, data and stop), plus 1 to 40
// preamble slots ahead of them when the item opens a frame.
// The slot sequencer emits at most one slot per cycle into the output register.
// Synchronous reset: carrier off, frame closed, preamble_ticks back to 16.
// A stalled output register holds the sequencer in place; the next item is
// taken while the final slot of the previous one still waits in the register.
module biphase_mark_frame_transmitter import bmft_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_wr_en,
  input  logic [PRE_W-1:0] cfg_wr_data,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [7:0]       data_byte,
  input  logic             last_byte,
  output logic             out_valid,
  input  logic             out_ready,
  output logic             line_level,
  output logic [1:0]       slot_kind,
  output logic             last,
  output logic             frame_end
);

  `include "biphase_mark_frame_transmitter_assert.svh"

  cmd_t    cmd;
  status_t status;

  // Sequencer: walks preamble, start, data and stop phases slot by slot.
  bmft_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // Datapath: carrier level, frame state, byte shifter, slot counter and
  // the output register.
  bmft_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .data_byte   (data_byte),
    .last_byte   (last_byte),
    .out_ready   (out_ready),
    .cmd         (cmd),
    .status      (status),
    .out_valid   (out_valid),
    .line_level  (line_level),
    .slot_kind   (slot_kind),
    .last        (last),
    .frame_end   (frame_end)
  );

  // An accepted item keeps the sequencer busy on the next cycle.
  `BMFT_ASSERT_NXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
  // A frame only ends on the final slot of an item.
  `BMFT_ASSERT_IMP(a_frame_end_on_last, out_valid && frame_end, last)
  // The final slot of an item is always a stop slot.
  `BMFT_ASSERT_IMP(a_last_is_stop, out_valid && last, slot_kind == KIND_STOP)
  // The sequencer never writes a slot over one that is still waiting.
  `BMFT_ASSERT_IMP(a_no_overwrite, cmd.emit, !out_valid || out_ready)

endmodule
